@@ src/gic_pkg.sv @@
// shared widths, command codes and default grid size for the grid connectivity block
`default_nettype none
package gic_pkg;

	localparam int CMD_W     = 2;
	localparam int COORD_W   = 6;
	localparam int ROWS_DEF  = 64;
	localparam int COLS_DEF  = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_PATH   = 2'd1,
		CMD_EXISTS = 2'd2
	} cmd_t;

endpackage
`default_nettype wire

@@ src/gic_ram.sv @@
// single read, single write synchronous cell memory with registered read data
`default_nettype none
module gic_ram #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 13
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ src/grid_incremental_connectivity.sv @@
// top level: command sequencer, label scan and response register around the cell memory
//
//  channel   handshake             payload
//  command   cmd_valid/cmd_stall   cmd, lat_a, lon_a, lat_b, lon_b
//  response  rsp_valid/rsp_stall   answer
//
// after reset a clearing pass writes every cell while cmd_stall stays high. exists and
// path queries answer after one memory read per looked-up cell.
// an add of a free in-grid cell runs a relabel scan when a neighbor is valid:
// the scan reads one cell per cycle and writes back matching cells via the single port pair.
// one command beat is worked at a time; a held response does not block the next command
// beat until that command's own result is ready.
`default_nettype none
module grid_incremental_connectivity #(
	parameter int GRID_ROWS = gic_pkg::ROWS_DEF,
	parameter int GRID_COLS = gic_pkg::COLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_stall,
	input  wire logic [gic_pkg::CMD_W-1:0]   cmd,
	input  wire logic [gic_pkg::COORD_W-1:0] lat_a,
	input  wire logic [gic_pkg::COORD_W-1:0] lon_a,
	input  wire logic [gic_pkg::COORD_W-1:0] lat_b,
	input  wire logic [gic_pkg::COORD_W-1:0] lon_b,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic                             answer
);
	import gic_pkg::*;

	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int DATA_W     = IDX_W + 1;
	localparam int SLOTS      = 5;
	localparam int TAG_W      = 3;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_READ  = 9'b000000100,
		S_WAIT  = 9'b000001000,
		S_EVAL  = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_DRAIN = 9'b001000000,
		S_WRA   = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [CMD_W-1:0]   cmd_q;
	logic               a_ok_q;
	logic               b_ok_q;
	logic [IDX_W-1:0]   idx_a_q;
	logic [IDX_W-1:0]   idx_b_q;
	logic [IDX_W-1:0]   nb_addr_q [4];
	logic [3:0]         nb_ok_q;
	logic [TAG_W-1:0]   rd_cnt_q;
	logic               rd_v_s1;
	logic [TAG_W-1:0]   rd_tag_s1;
	logic               slot_v_q [SLOTS];
	logic [IDX_W-1:0]   slot_l_q [SLOTS];
	logic [IDX_W-1:0]   nlab_q [4];
	logic [3:0]         nlab_v_q;
	logic               sc_v_s1;
	logic [IDX_W-1:0]   sc_addr_s1;
	logic               ans_q;
	logic               rsp_valid_q;

	logic               accept;
	logic [IDX_W-1:0]   idx_a_w;
	logic [IDX_W-1:0]   idx_b_w;
	logic [3:0]         nb_ok_w;
	logic [3:0]         nb_hit;
	logic [TAG_W-1:0]   rd_last;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [DATA_W-1:0]  rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [DATA_W-1:0]  wr_data;
	logic               sc_hit;
	logic               rsp_load;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	assign idx_a_w = IDX_W'(lat_a * GRID_COLS + lon_a);
	assign idx_b_w = IDX_W'(lat_b * GRID_COLS + lon_b);
	assign nb_ok_w[0] = (lat_a != '0);
	assign nb_ok_w[1] = (32'(lat_a) + 32'd1) < GRID_ROWS;
	assign nb_ok_w[2] = (lon_a != '0);
	assign nb_ok_w[3] = (32'(lon_a) + 32'd1) < GRID_COLS;

	assign nb_hit = nb_ok_q & {slot_v_q[4], slot_v_q[3], slot_v_q[2], slot_v_q[1]};

	always_comb begin
		case (cmd_q)
			CMD_ADD:  rd_last = TAG_W'(SLOTS - 1);
			CMD_PATH: rd_last = TAG_W'(1);
			default:  rd_last = '0;
		endcase
	end

	always_comb begin
		sc_hit = 1'b0;
		for (int j = 0; j < 4; j++) begin
			if (nlab_v_q[j] && (rd_data[IDX_W-1:0] == nlab_q[j])) begin
				sc_hit = 1'b1;
			end
		end
		sc_hit = sc_hit && rd_data[IDX_W];
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q;
		case (state_q)
			S_READ: begin
				rd_en = 1'b1;
				case (rd_cnt_q)
					3'd0:    rd_addr = idx_a_q;
					3'd1:    rd_addr = (cmd_q == CMD_PATH) ? idx_b_q : nb_addr_q[0];
					3'd2:    rd_addr = nb_addr_q[1];
					3'd3:    rd_addr = nb_addr_q[2];
					default: rd_addr = nb_addr_q[3];
				endcase
			end
			S_SCAN: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (sc_v_s1) begin
			wr_en   = sc_hit;
			wr_addr = sc_addr_s1;
			wr_data = {1'b1, idx_a_q};
		end else if (state_q == S_WRA) begin
			wr_en   = 1'b1;
			wr_addr = idx_a_q;
			wr_data = {1'b1, idx_a_q};
		end
	end

	gic_ram #(
		.DEPTH  (CELL_COUNT),
		.DATA_W (DATA_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			sc_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_READ);
			sc_v_s1 <= (state_q == S_SCAN);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(CELL_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_cnt_q <= '0;
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == rd_last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					cnt_q <= '0;
					if (cmd_q == CMD_ADD && a_ok_q && !slot_v_q[0]) begin
						state_q <= (nb_hit != '0) ? S_SCAN : S_WRA;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(CELL_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_WRA;
				end
				S_WRA: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= cmd;
			a_ok_q       <= (lat_a < GRID_ROWS) && (lon_a < GRID_COLS);
			b_ok_q       <= (lat_b < GRID_ROWS) && (lon_b < GRID_COLS);
			idx_a_q      <= idx_a_w;
			idx_b_q      <= idx_b_w;
			nb_addr_q[0] <= IDX_W'(lat_a * GRID_COLS + lon_a - GRID_COLS);
			nb_addr_q[1] <= IDX_W'(lat_a * GRID_COLS + lon_a + GRID_COLS);
			nb_addr_q[2] <= idx_a_w - 1'b1;
			nb_addr_q[3] <= idx_a_w + 1'b1;
			nb_ok_q      <= nb_ok_w;
		end
		rd_tag_s1  <= rd_cnt_q;
		sc_addr_s1 <= cnt_q;
		if (rd_v_s1) begin
			slot_v_q[rd_tag_s1] <= rd_data[IDX_W];
			slot_l_q[rd_tag_s1] <= rd_data[IDX_W-1:0];
		end
		if (state_q == S_EVAL) begin
			for (int j = 0; j < 4; j++) begin
				nlab_q[j] <= slot_l_q[j+1];
			end
			nlab_v_q <= nb_hit;
			case (cmd_q)
				CMD_PATH: ans_q <= a_ok_q && b_ok_q && slot_v_q[0] && slot_v_q[1] &&
					(slot_l_q[0] == slot_l_q[1]);
				CMD_EXISTS: ans_q <= a_ok_q && slot_v_q[0];
				default: ans_q <= 1'b0;
			endcase
		end
		if (state_q == S_WRA) begin
			ans_q <= 1'b1;
		end
		if (rsp_load) begin
			answer <= ans_q;
		end
	end

	// no read and write of the same cell in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write of the same cell in one cycle");

	// writes stay inside the grid
	a_wr_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < CELL_COUNT))
		else $error("cell write outside the grid");

	// one command in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("command beat taken while one is in flight");

	// no response during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !rsp_valid)
		else $error("response during clearing pass");

endmodule
`default_nettype wire
